// ===== rtl/core/sad_pkg.sv =====
package sad_pkg;

	localparam int SLOTS_DEF       = 256;
	localparam int BLOCK_BYTES_DEF = 256;

	localparam int ACTION_W   = 3;
	localparam int SLOT_W     = 10;
	localparam int MOFF_W     = 16;
	localparam int MSIZE_W    = 9;
	localparam int STATUS_W   = 2;
	localparam int INDEX_W    = 8;
	localparam int LIVE_W     = 9;
	localparam int SPAN_W     = 17;
	localparam int CAP_W      = 9;

	localparam logic [SPAN_W-1:0] SPAN_MAX = {SPAN_W{1'b1}};

	typedef enum logic [ACTION_W-1:0] {
		ACT_ALLOC = 3'd0,
		ACT_INST  = 3'd1,
		ACT_REL   = 3'd2,
		ACT_MARK  = 3'd3,
		ACT_CLEAR = 3'd4
	} act_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_OVF   = 2'd3
	} status_t;

	typedef struct packed {
		logic push;
		logic pop;
	} stk_ctl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} stk_sts_t;

endpackage

// ===== rtl/core/sad_req_if.sv =====
interface sad_req_if;
	logic                         valid;
	logic                         ready;
	logic [sad_pkg::ACTION_W-1:0] action;
	logic [sad_pkg::SLOT_W-1:0]   slot;
	logic [sad_pkg::MOFF_W-1:0]   mark_offset;
	logic [sad_pkg::MSIZE_W-1:0]  mark_size;

	modport source (output valid, action, slot, mark_offset, mark_size, input ready);
	modport sink (input valid, action, slot, mark_offset, mark_size, output ready);
endinterface

// ===== rtl/core/sad_rsp_if.sv =====
interface sad_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [sad_pkg::STATUS_W-1:0] status;
	logic [sad_pkg::INDEX_W-1:0]  slot_index;
	logic [sad_pkg::LIVE_W-1:0]   live_slots;
	logic                         dirty_valid;
	logic [sad_pkg::SPAN_W-1:0]   dirty_offset;
	logic [sad_pkg::SPAN_W-1:0]   dirty_size;

	modport source (output valid, status, slot_index, live_slots, dirty_valid,
		dirty_offset, dirty_size, input ready);
	modport sink (input valid, status, slot_index, live_slots, dirty_valid,
		dirty_offset, dirty_size, output ready);
endinterface

// ===== rtl/core/sad_stack.sv =====
module sad_stack #(
	parameter int SLOTS = sad_pkg::SLOTS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  sad_pkg::stk_ctl_t                          ctl,
	input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] push_data,
	output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] top,
	output sad_pkg::stk_sts_t                          sts
);
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	logic [IW-1:0] mem [SLOTS];
	logic [IW-1:0] rd_q;
	logic [IW-1:0] byp_data_q;
	logic          byp_q;
	logic [CW-1:0] depth_q;
	logic [CW-1:0] depth_d;
	logic [IW-1:0] rd_addr;

	always_comb begin
		depth_d = depth_q;
		if (ctl.push) begin
			depth_d = depth_q + CW'(1);
		end else if (ctl.pop) begin
			depth_d = depth_q - CW'(1);
		end
		rd_addr = IW'(depth_d - CW'(1));
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[depth_q[IW-1:0]] <= push_data;
		end
		rd_q <= mem[rd_addr];
		byp_data_q <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			byp_q   <= 1'b0;
		end else begin
			depth_q <= depth_d;
			byp_q   <= ctl.push;
		end
	end

	assign top       = byp_q ? byp_data_q : rd_q;
	assign sts.empty = (depth_q == '0);
	assign sts.full  = (depth_q == CW'(SLOTS));
endmodule

// ===== rtl/core/sad_span.sv =====
module sad_span (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       merge,
	input  logic                       clear,
	input  logic [sad_pkg::SPAN_W-1:0] lo,
	input  logic [sad_pkg::SPAN_W-1:0] hi,
	output logic [sad_pkg::SPAN_W-1:0] begin_d,
	output logic [sad_pkg::SPAN_W-1:0] end_d
);
	logic [sad_pkg::SPAN_W-1:0] span_begin_q;
	logic [sad_pkg::SPAN_W-1:0] span_end_q;
	logic                       empty;

	assign empty = (span_begin_q == '0) && (span_end_q == '0);

	always_comb begin
		begin_d = span_begin_q;
		end_d   = span_end_q;
		if (clear) begin
			begin_d = '0;
			end_d   = '0;
		end else if (merge) begin
			if (empty) begin
				begin_d = lo;
				end_d   = hi;
			end else begin
				if (lo < span_begin_q) begin
					begin_d = lo;
				end
				if (hi > span_end_q) begin
					end_d = hi;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_begin_q <= '0;
			span_end_q   <= '0;
		end else begin
			span_begin_q <= begin_d;
			span_end_q   <= end_d;
		end
	end
endmodule

// ===== rtl/core/slot_allocator_dirty_range.sv =====
// an accepted request beat is held in the input register, then its response beat is loaded into the response register
// throughput: one request per cycle, held back only by response backpressure
// the free stack top is kept ready by a registered read of the next entry plus a push bypass
// reset: no slots live, free stack and dirty span empty, capacity at SLOTS
// free stack entries are not cleared; only pushed entries are ever popped
module slot_allocator_dirty_range #(
	parameter int SLOTS       = sad_pkg::SLOTS_DEF,
	parameter int BLOCK_BYTES = sad_pkg::BLOCK_BYTES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	sad_req_if.sink                   req,
	sad_rsp_if.source                 rsp,
	input  logic                      cfg_we,
	input  logic [sad_pkg::CAP_W-1:0] cfg_wdata
);
	localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW   = $clog2(SLOTS + 1);
	localparam int CPW  = (CW > sad_pkg::CAP_W) ? CW : sad_pkg::CAP_W;
	localparam int KW   = (CPW > sad_pkg::SLOT_W) ? CPW : sad_pkg::SLOT_W;
	localparam int BBW  = $clog2(BLOCK_BYTES + 1);
	localparam int AW0  = IW + BBW + 1;
	localparam int AW   = (AW0 > sad_pkg::SPAN_W + 1) ? AW0 : sad_pkg::SPAN_W + 1;

	logic [CPW-1:0]                 cap_q;
	logic [CW-1:0]                  cap_eff;
	logic                           valid_s1;
	logic [sad_pkg::ACTION_W-1:0]   action_s1;
	logic [sad_pkg::SLOT_W-1:0]     slot_s1;
	logic [sad_pkg::MOFF_W-1:0]     moff_s1;
	logic [sad_pkg::MSIZE_W-1:0]    msize_s1;
	logic                           advance;
	logic [CW-1:0]                  next_fresh_q;
	logic [CW-1:0]                  live_q;

	sad_pkg::stk_ctl_t              stk_ctl;
	sad_pkg::stk_sts_t              stk_sts;
	logic [IW-1:0]                  stk_top;
	logic [IW-1:0]                  slot_idx;

	logic                           slot_ok;
	logic                           fresh_ok;
	logic                           take;
	logic                           take_ok;
	logic                           fresh_use;
	logic                           rel_ok;
	logic                           do_mark;
	logic                           do_clear;
	logic                           mark_blk;
	logic [IW-1:0]                  granted;
	logic [IW-1:0]                  blk_idx;
	logic [AW-1:0]                  blk_off;
	logic [AW-1:0]                  blk_hi;
	logic [sad_pkg::SPAN_W-1:0]     merge_lo;
	logic [sad_pkg::SPAN_W-1:0]     merge_hi;
	logic [sad_pkg::SPAN_W-1:0]     begin_d;
	logic [sad_pkg::SPAN_W-1:0]     end_d;
	sad_pkg::status_t               status;
	logic                           dirty_valid;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CPW'(SLOTS);
		end else if (cfg_we) begin
			cap_q <= CPW'(cfg_wdata);
		end
	end

	assign cap_eff = (cap_q > CPW'(SLOTS)) ? CW'(SLOTS) : CW'(cap_q);

	// input register
	assign advance   = valid_s1 && (!rsp.valid || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			action_s1 <= req.action;
			slot_s1   <= req.slot;
			moff_s1   <= req.mark_offset;
			msize_s1  <= req.mark_size;
		end
	end

	// request decode
	always_comb begin
		slot_ok  = KW'(slot_s1) < KW'(cap_eff);
		fresh_ok = next_fresh_q < cap_eff;
		take     = 1'b0;
		rel_ok   = 1'b0;
		do_mark  = 1'b0;
		do_clear = 1'b0;
		status   = sad_pkg::ST_OK;
		unique case (sad_pkg::act_t'(action_s1))
			sad_pkg::ACT_ALLOC: begin
				take = 1'b1;
			end
			sad_pkg::ACT_INST: begin
				take = slot_ok;
				if (!slot_ok) begin
					status = sad_pkg::ST_RANGE;
				end
			end
			sad_pkg::ACT_REL: begin
				rel_ok = slot_ok;
				if (!slot_ok) begin
					status = sad_pkg::ST_RANGE;
				end else if (stk_sts.full) begin
					status = sad_pkg::ST_OVF;
				end
			end
			sad_pkg::ACT_MARK: begin
				do_mark = 1'b1;
			end
			sad_pkg::ACT_CLEAR: begin
				do_clear = 1'b1;
			end
			default: begin
			end
		endcase
		take_ok   = take && (!stk_sts.empty || fresh_ok);
		fresh_use = take && stk_sts.empty && fresh_ok;
		if (take && !take_ok) begin
			status = sad_pkg::ST_FULL;
		end
	end

	assign slot_idx    = IW'(slot_s1);
	assign granted     = take_ok ? (stk_sts.empty ? IW'(next_fresh_q) : stk_top) : '0;
	assign blk_idx     = take_ok ? granted : slot_idx;
	assign mark_blk    = take_ok || rel_ok;
	assign stk_ctl.pop  = advance && take && !stk_sts.empty;
	assign stk_ctl.push = advance && rel_ok && !stk_sts.full;

	sad_stack #(
		.SLOTS(SLOTS)
	) u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (stk_ctl),
		.push_data(slot_idx),
		.top      (stk_top),
		.sts      (stk_sts)
	);

	// span bounds of the touched block or the marked range
	always_comb begin
		blk_off = AW'(blk_idx) * AW'(BLOCK_BYTES);
		blk_hi  = blk_off + AW'(BLOCK_BYTES);
		if (mark_blk) begin
			merge_lo = (blk_off > AW'(sad_pkg::SPAN_MAX)) ? sad_pkg::SPAN_MAX
				: sad_pkg::SPAN_W'(blk_off);
			merge_hi = (blk_hi > AW'(sad_pkg::SPAN_MAX)) ? sad_pkg::SPAN_MAX
				: sad_pkg::SPAN_W'(blk_hi);
		end else begin
			merge_lo = sad_pkg::SPAN_W'(moff_s1);
			merge_hi = sad_pkg::SPAN_W'(moff_s1) + sad_pkg::SPAN_W'(msize_s1);
		end
	end

	sad_span u_span (
		.clk    (clk),
		.arst_n (arst_n),
		.merge  (advance && (mark_blk || do_mark)),
		.clear  (advance && do_clear),
		.lo     (merge_lo),
		.hi     (merge_hi),
		.begin_d(begin_d),
		.end_d  (end_d)
	);

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_fresh_q <= '0;
			live_q       <= '0;
		end else if (advance) begin
			if (fresh_use) begin
				next_fresh_q <= next_fresh_q + CW'(1);
			end
			if (take_ok && (live_q < CW'(SLOTS))) begin
				live_q <= live_q + CW'(1);
			end else if (rel_ok && (live_q != '0)) begin
				live_q <= live_q - CW'(1);
			end
		end
	end

	// response register
	assign dirty_valid = end_d > begin_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (advance) begin
			rsp.valid <= 1'b1;
		end else if (rsp.ready) begin
			rsp.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp.status       <= status;
			rsp.slot_index   <= sad_pkg::INDEX_W'(granted);
			rsp.dirty_valid  <= dirty_valid;
			rsp.dirty_offset <= dirty_valid ? begin_d : '0;
			rsp.dirty_size   <= dirty_valid ? (end_d - begin_d) : '0;
			if (take_ok && (live_q < CW'(SLOTS))) begin
				rsp.live_slots <= sad_pkg::LIVE_W'(live_q + CW'(1));
			end else if (rel_ok && (live_q != '0)) begin
				rsp.live_slots <= sad_pkg::LIVE_W'(live_q - CW'(1));
			end else begin
				rsp.live_slots <= sad_pkg::LIVE_W'(live_q);
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= CW'(SLOTS))
		else $error("live count above table size");

	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_fresh_q <= CW'(SLOTS))
		else $error("fresh slot pointer above table size");

	a_full_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status != sad_pkg::ST_OK)) |-> (rsp.slot_index == '0))
		else $error("slot granted on failed request");

	a_span_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.dirty_valid) |-> (rsp.dirty_offset == '0 && rsp.dirty_size == '0))
		else $error("dirty span reported while not valid");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		stk_ctl.pop |-> !stk_sts.empty)
		else $error("pop from empty free stack");
`endif
endmodule
